/* hdl/cfmb_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the framed message builder.
`timescale 1ns / 1ps
package cfmb_pkg;

  localparam int MAX_FRAME_BYTES = 128;
  localparam int HDR_OVERHEAD    = 10;
  localparam int MAX_PAYLOAD     = MAX_FRAME_BYTES - HDR_OVERHEAD;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 16;
  localparam int LEN_W  = 7;
  localparam int TOT_W  = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [BYTE_W-1:0] SYNC_A   = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_B   = 8'h55;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // Output sequence positions inside one command.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SYNC_A  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC_B  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_TOT_HI  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_TOT_LO  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CODE_HI = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CODE_LO = 4'd5;
  localparam logic [STEP_W-1:0] STEP_TYPE    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LEN_HI  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LEN_LO  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_HDR_CRC = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PAY_DATA = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PAY_CRC  = 4'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                is_start;
    logic [CODE_W-1:0]   code;
    logic [BYTE_W-1:0]   mtype;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   data;
    logic                ends_frame;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* hdl/cfmb_front.sv */
// Front end: classifies input items, tracks the payload count and pushes commands into the queue.
`timescale 1ns / 1ps
module cfmb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          func,
  input  logic [cfmb_pkg::CODE_W-1:0]   msg_code,
  input  logic [cfmb_pkg::BYTE_W-1:0]   msg_type,
  input  logic [cfmb_pkg::LEN_W-1:0]    payload_len,
  input  logic [cfmb_pkg::BYTE_W-1:0]   payload_byte,
  output logic                          push_valid,
  output cfmb_pkg::cmd_t                push_cmd
);

  localparam logic [cfmb_pkg::TOT_W-1:0] MaxPayloadW = cfmb_pkg::TOT_W'(cfmb_pkg::MAX_PAYLOAD);

  logic [cfmb_pkg::LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [cfmb_pkg::LEN_W-1:0] sat_len;
  logic                       is_start;

  assign is_start = (func == cfmb_pkg::FUNC_START);

  always_comb begin
    if (cfmb_pkg::TOT_W'(payload_len) > MaxPayloadW) begin
      sat_len = cfmb_pkg::LEN_W'(cfmb_pkg::MAX_PAYLOAD);
    end else begin
      sat_len = payload_len;
    end
  end

  // A payload byte outside a frame is accepted and dropped.
  always_comb begin
    push_valid          = 1'b0;
    bytes_left_nxt      = bytes_left_r;
    push_cmd.is_start   = is_start;
    push_cmd.code       = msg_code;
    push_cmd.mtype      = msg_type;
    push_cmd.len        = sat_len;
    push_cmd.data       = payload_byte;
    push_cmd.ends_frame = (bytes_left_r == cfmb_pkg::LEN_W'(1));
    if (accept) begin
      if (is_start) begin
        push_valid     = 1'b1;
        bytes_left_nxt = sat_len;
      end else if (bytes_left_r != '0) begin
        push_valid     = 1'b1;
        bytes_left_nxt = bytes_left_r - cfmb_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

/* hdl/cfmb_queue.sv */
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
module cfmb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  cfmb_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cfmb_pkg::cmd_t  head_cmd
);

  cfmb_pkg::cmd_t                  mem [cfmb_pkg::QUEUE_DEPTH];
  logic [cfmb_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cfmb_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full       = (count_r == cfmb_pkg::QCNT_W'(cfmb_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + cfmb_pkg::QCNT_W'(1);
    end else if (pop && !push_valid) begin
      count_nxt = count_r - cfmb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + cfmb_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cfmb_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command popped from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cfmb_pkg::QCNT_W'(cfmb_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

/* hdl/cfmb_back.sv */
// Back end: steps through each command's bytes, runs the CRC and drives the output register.
`timescale 1ns / 1ps
module cfmb_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                head_valid,
  input  cfmb_pkg::cmd_t                      head_cmd,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cfmb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);

  logic [cfmb_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [cfmb_pkg::BYTE_W-1:0] crc_r, crc_nxt, crc_base;
  logic                        out_valid_r, out_valid_nxt;
  logic [cfmb_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        out_crc_r, out_crc_nxt;
  logic                        emit, last_step, crc_step;
  logic [cfmb_pkg::BYTE_W-1:0] data_byte, hdr_byte;
  logic [cfmb_pkg::TOT_W-1:0]  total, len_w;

  assign emit  = head_valid && (!out_valid_r || out_tready);
  assign len_w = cfmb_pkg::TOT_W'(head_cmd.len);
  assign total = cfmb_pkg::TOT_W'(cfmb_pkg::HDR_OVERHEAD) + len_w;

  always_comb begin
    case (step_r)
      cfmb_pkg::STEP_SYNC_A:  hdr_byte = cfmb_pkg::SYNC_A;
      cfmb_pkg::STEP_SYNC_B:  hdr_byte = cfmb_pkg::SYNC_B;
      cfmb_pkg::STEP_TOT_HI:  hdr_byte = total[15:8];
      cfmb_pkg::STEP_TOT_LO:  hdr_byte = total[7:0];
      cfmb_pkg::STEP_CODE_HI: hdr_byte = head_cmd.code[15:8];
      cfmb_pkg::STEP_CODE_LO: hdr_byte = head_cmd.code[7:0];
      cfmb_pkg::STEP_TYPE:    hdr_byte = head_cmd.mtype;
      cfmb_pkg::STEP_LEN_HI:  hdr_byte = len_w[15:8];
      cfmb_pkg::STEP_LEN_LO:  hdr_byte = len_w[7:0];
      default:                hdr_byte = '0;
    endcase
  end

  always_comb begin
    if (head_cmd.is_start) begin
      crc_step  = (step_r == cfmb_pkg::STEP_HDR_CRC);
      last_step = (head_cmd.len == '0) ? (step_r == cfmb_pkg::STEP_HDR_CRC)
                                       : (step_r == cfmb_pkg::STEP_LEN_LO);
      data_byte = hdr_byte;
    end else begin
      crc_step  = (step_r == cfmb_pkg::STEP_PAY_CRC);
      last_step = head_cmd.ends_frame ? (step_r == cfmb_pkg::STEP_PAY_CRC)
                                      : (step_r == cfmb_pkg::STEP_PAY_DATA);
      data_byte = head_cmd.data;
    end
    // A start restarts the CRC, which also drops any abandoned frame.
    if (head_cmd.is_start && (step_r == cfmb_pkg::STEP_SYNC_A)) begin
      crc_base = '0;
    end else begin
      crc_base = crc_r;
    end
  end

  always_comb begin
    pop           = 1'b0;
    step_nxt      = step_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_crc_nxt   = out_crc_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (crc_step) begin
        out_byte_nxt = crc_r;
        out_crc_nxt  = 1'b1;
        crc_nxt      = '0;
      end else begin
        out_byte_nxt = data_byte;
        out_crc_nxt  = 1'b0;
        crc_nxt      = cfmb_pkg::crc8_update(crc_base, data_byte);
      end
      if (last_step) begin
        pop      = 1'b1;
        step_nxt = '0;
      end else begin
        step_nxt = step_r + cfmb_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_crc_r  <= out_crc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_crc_r;
  assign out_tlast  = out_crc_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= cfmb_pkg::STEP_HDR_CRC)
    else $error("byte sequencer step out of range");

  a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && crc_step) |=> (crc_r == '0))
    else $error("CRC not cleared after the CRC byte");

  a_pop_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (emit && last_step))
    else $error("command retired without emitting its last byte");

endmodule

/* hdl/crc8_framed_message_builder.sv */
// Top level of the CRC-8 framed message builder: front end, command queue and byte sequencer.
// With the queue empty, an accepted item is first written into the command queue, and its first
// output byte is then registered in the output register of the sequencer.
// Output bytes: a payload byte gives one byte, the final payload byte two (data and CRC),
// a start item nine bytes (ten when the payload length is zero); the one-byte output register
// of the sequencer holds its byte while out_tready is low, and the four-entry queue absorbs input bursts.
// Reset (rst_n low, synchronous) empties the queue and output register and leaves no frame open.
`timescale 1ns / 1ps
module crc8_framed_message_builder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] msg_code, [23:16] msg_type, [30:24] payload_len, [38:31] payload_byte, [39] zero
  input  logic [cfmb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] func
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] out_byte
  output logic [cfmb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] is_crc
  output logic                                out_tuser,
  output logic                                out_tlast
);

  logic           q_full, push_valid, pop, head_valid;
  cfmb_pkg::cmd_t push_cmd, head_cmd;

  assign in_tready = !q_full;

  cfmb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_tvalid && in_tready),
    .func         (in_tuser),
    .msg_code     (in_tdata[15:0]),
    .msg_type     (in_tdata[23:16]),
    .payload_len  (in_tdata[30:24]),
    .payload_byte (in_tdata[38:31]),
    .push_valid   (push_valid),
    .push_cmd     (push_cmd)
  );

  cfmb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  cfmb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
